[hw/rtl/segregated_fit_heap_allocator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the segregated-fit allocator checker
// Implication checks, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfha_pkg.sv]
// ----------------------------------------------------------------------------
// sfha_pkg
// Types, codes and helpers shared by the segregated-fit allocator.
// ----------------------------------------------------------------------------
package sfha_pkg;

    // internal width of granule counts and addresses
    localparam int CW = 20;
    localparam int CLW = 5;
    localparam logic [CLW-1:0] CLS_NONE = 5'd17;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC_W1,
        S_ALLOC_W2,
        S_FL_RD,
        S_FL_FOOT,
        S_FL_HEAD,
        S_FR_RD,
        S_FR_HEAD,
        S_FW1,
        S_FW2,
        S_RESP
    } t_state;

    // size class: ceil(log2(n)) capped at 16, as a count of powers below n
    function automatic logic [CLW-1:0] size_class(input logic [CW-1:0] n);
        logic [CLW-1:0] c;
        c = '0;
        for (int i = 0; i < 16; i++) begin
            if ((CW'(1) << i) < n) c = c + 1'b1;
        end
        return c;
    endfunction

endpackage

[hw/rtl/sfha_tag_ram.sv]
// ----------------------------------------------------------------------------
// sfha_tag_ram
// Boundary tag store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfha_tag_ram #(
    parameter int AW = 12,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) o_rdata <= mem[i_raddr];
    end

endmodule

[hw/rtl/segregated_fit_heap_allocator_top.sv]
// Scan: allocate and free scan the head tags up to the end pointer, one
// granule a cycle; a request rejected at decode or of unknown kind skips
// the scan and goes straight to the result.
// Throughput: one request at a time, busy until the result; results cannot stall.
// Reset: synchronous, active low; then a clearing pass over all POOL_GRANULES
// entries zeroes both tag RAMs while busy is high; the reset command does too.
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator_top
// Segregated-fit allocator with boundary-tag coalescing over a granule pool.
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator_top
    import sfha_pkg::*;
#(
    parameter int POOL_GRANULES = 4096,
    parameter int GRANULE_BYTES = 64,   // power of two
    parameter int MIN_GRANULES  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [17:0] i_block_addr,
    input  logic [18:0] i_block_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [17:0] o_granted_addr,
    output logic [11:0] o_free_block_count,
    output logic [18:0] o_free_byte_total
);

    localparam int AW  = $clog2(POOL_GRANULES);
    localparam int DW  = $clog2(POOL_GRANULES + 1);
    localparam int GBL = $clog2(GRANULE_BYTES);

    // control and working registers
    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    t_status         r_st, n_st;
    logic [12:0]     r_pool;
    logic [CW-1:0]   r_g, n_g;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_pg, n_pg;
    logic [CW-1:0]   r_req, n_req;
    logic [CW-1:0]   r_a, n_a;
    logic [CW-1:0]   r_ao, n_ao;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_fs, n_fs;
    logic [CW-1:0]   r_bg, n_bg;
    logic [CW-1:0]   r_bs, n_bs;
    logic [CLW-1:0]  r_bc, n_bc;
    logic            r_hit, n_hit;
    logic            r_lm, n_lm;
    logic            r_rm, n_rm;
    logic [CW-1:0]   r_bump, n_bump;
    logic [CW-1:0]   r_blk, n_blk;
    logic [CW-1:0]   r_gran, n_gran;
    logic [17:0]     r_grant, n_grant;

    // result registers
    logic            r_done, n_done;
    logic [1:0]      r_ostat, n_ostat;
    logic [17:0]     r_oaddr, n_oaddr;
    logic [11:0]     r_ocnt, n_ocnt;
    logic [18:0]     r_obytes, n_obytes;

    // tag RAM ports
    logic            h_we, f_we, h_re, f_re;
    logic [AW-1:0]   h_wa, f_wa, h_ra, f_ra;
    logic [DW-1:0]   h_wd, f_wd, h_q, f_q;

    sfha_tag_ram #(.AW(AW), .DW(DW)) u_head (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_re(h_re), .i_raddr(h_ra), .o_rdata(h_q)
    );

    sfha_tag_ram #(.AW(AW), .DW(DW)) u_foot (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_re(f_re), .i_raddr(f_ra), .o_rdata(f_q)
    );

    // request decode
    logic [CW-1:0] in_a, in_n, lim, hq, fq, left, sum_an;
    logic          in_misal, in_bad_size;
    logic [CLW-1:0] hcls;

    assign in_a        = CW'(i_block_addr >> GBL);
    assign in_n        = CW'(i_block_bytes >> GBL);
    assign in_misal    = (i_block_addr & 18'(GRANULE_BYTES - 1)) != '0;
    assign in_bad_size = ((i_block_bytes & 19'(GRANULE_BYTES - 1)) != '0)
                         || (in_n < CW'(MIN_GRANULES));
    assign lim    = (CW'(r_pool) < CW'(POOL_GRANULES)) ? CW'(r_pool) : CW'(POOL_GRANULES);
    assign hq     = CW'(h_q);
    assign fq     = CW'(f_q);
    assign hcls   = size_class(hq);
    assign left   = r_bs - r_req;
    assign sum_an = r_a + r_n;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // next state and datapath
    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_st = r_st;
        n_g = r_g; n_pend = r_pend; n_pg = r_pg; n_req = r_req;
        n_a = r_a; n_ao = r_ao; n_n = r_n; n_fs = r_fs;
        n_bg = r_bg; n_bs = r_bs; n_bc = r_bc; n_hit = r_hit;
        n_lm = r_lm; n_rm = r_rm; n_bump = r_bump; n_blk = r_blk;
        n_gran = r_gran; n_grant = r_grant;
        n_done = 1'b0; n_ostat = r_ostat; n_oaddr = r_oaddr;
        n_ocnt = r_ocnt; n_obytes = r_obytes;
        h_we = 1'b0; f_we = 1'b0; h_re = 1'b0; f_re = 1'b0;
        h_wa = r_g[AW-1:0]; f_wa = r_g[AW-1:0]; h_wd = '0; f_wd = '0;
        h_ra = r_g[AW-1:0]; f_ra = r_g[AW-1:0];

        unique case (r_state)
            // zero both tag stores
            S_CLEAR: begin
                h_we = 1'b1; f_we = 1'b1;
                n_g  = r_g + 1'b1;
                if (r_g == CW'(POOL_GRANULES - 1)) begin
                    n_state = (r_cmd == CMD_RESET) ? S_RESP : S_IDLE;
                end
            end

            // take a request
            S_IDLE: begin
                if (start) begin
                    n_cmd = t_cmd'(i_cmd); n_st = ST_OK; n_grant = '0;
                    n_g = '0; n_pend = 1'b0; n_bc = CLS_NONE; n_hit = 1'b0;
                    n_lm = 1'b0; n_rm = 1'b0;
                    n_a = in_a; n_ao = in_a; n_n = in_n; n_req = in_n;
                    unique case (t_cmd'(i_cmd))
                        CMD_ALLOC: begin
                            if (in_bad_size) begin
                                n_st = ST_BAD_SIZE; n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            if (in_misal) begin
                                n_st = ST_BAD_ADDR; n_state = S_RESP;
                            end else if (in_bad_size) begin
                                n_st = ST_BAD_SIZE; n_state = S_RESP;
                            end else if (in_a + in_n > r_bump) begin
                                n_st = ST_BAD_ADDR; n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_RESET: begin
                            n_bump = '0; n_blk = '0; n_gran = '0;
                            n_state = S_CLEAR;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            // walk the head tags in address order, one read in flight
            S_SCAN: begin
                if (r_pend && hq != '0) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (hq >= r_req && hcls < r_bc) begin
                            n_bc = hcls; n_bg = r_pg; n_bs = hq;
                        end
                    end else if (r_pg < sum_an && r_a < r_pg + hq) begin
                        n_hit = 1'b1;
                    end
                end
                if (r_g < r_bump) begin
                    h_re = 1'b1; n_pend = 1'b1; n_pg = r_g; n_g = r_g + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_cmd == CMD_ALLOC) begin
                            if (r_bc != CLS_NONE) begin
                                n_state = S_ALLOC_W1;
                            end else if (r_bump + r_req <= lim) begin
                                n_grant = 18'(r_bump << GBL);
                                n_bump  = r_bump + r_req;
                                n_state = S_RESP;
                            end else begin
                                n_st = ST_NO_SPACE; n_state = S_RESP;
                            end
                        end else if (r_hit) begin
                            n_st = ST_BAD_ADDR; n_state = S_RESP;
                        end else begin
                            n_state = S_FL_RD;
                        end
                    end
                end
            end

            // take the chosen block, leave a valid tail on the lists
            S_ALLOC_W1: begin
                h_we = 1'b1; h_wa = r_bg[AW-1:0]; h_wd = '0;
                f_we = 1'b1; f_wa = AW'(r_bg + r_bs - 1'b1);
                n_grant = 18'(r_bg << GBL);
                if (left >= CW'(MIN_GRANULES)) begin
                    f_wd = DW'(left);
                    n_gran = r_gran - r_req;
                    n_state = S_ALLOC_W2;
                end else begin
                    f_wd = '0;
                    n_blk = r_blk - 1'b1;
                    n_gran = r_gran - r_bs;
                    n_state = S_RESP;
                end
            end

            S_ALLOC_W2: begin
                h_we = 1'b1; h_wa = AW'(r_bg + r_req); h_wd = DW'(left);
                n_state = S_RESP;
            end

            // left neighbor through its foot tag
            S_FL_RD: begin
                if (r_a != '0) begin
                    f_re = 1'b1; f_ra = AW'(r_a - 1'b1);
                    n_state = S_FL_FOOT;
                end else begin
                    n_state = S_FR_RD;
                end
            end

            S_FL_FOOT: begin
                if (fq != '0 && fq <= r_a) begin
                    h_re = 1'b1; h_ra = AW'(r_a - fq); n_fs = fq;
                    n_state = S_FL_HEAD;
                end else begin
                    n_state = S_FR_RD;
                end
            end

            S_FL_HEAD: begin
                if (hq == r_fs) begin
                    n_lm = 1'b1; n_a = r_a - r_fs; n_n = r_n + r_fs;
                end
                n_state = S_FR_RD;
            end

            // right neighbor through its head tag
            S_FR_RD: begin
                if (sum_an < r_bump) begin
                    h_re = 1'b1; h_ra = AW'(sum_an);
                    n_pg = sum_an;
                    n_state = S_FR_HEAD;
                end else begin
                    n_state = S_FW1;
                end
            end

            S_FR_HEAD: begin
                if (hq != '0) begin
                    n_rm = 1'b1; n_n = r_n + hq;
                end
                n_state = S_FW1;
            end

            // tags of the merged block
            S_FW1: begin
                h_we = 1'b1; h_wa = r_a[AW-1:0]; h_wd = DW'(r_n);
                f_we = 1'b1; f_wa = AW'(sum_an - 1'b1); f_wd = DW'(r_n);
                n_blk  = r_blk + 1'b1 - CW'(r_lm) - CW'(r_rm);
                n_gran = r_gran + r_req;
                n_state = S_FW2;
            end

            // clear the inner tags of absorbed neighbors
            S_FW2: begin
                h_we = r_rm; h_wa = r_pg[AW-1:0]; h_wd = '0;
                f_we = r_lm; f_wa = AW'(r_ao - 1'b1); f_wd = '0;
                n_state = S_RESP;
            end

            S_RESP: begin
                n_done   = 1'b1;
                n_ostat  = r_st;
                n_oaddr  = (r_st == ST_OK) ? r_grant : '0;
                n_ocnt   = r_blk[11:0];
                n_obytes = 19'(r_gran << GBL);
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cmd   <= CMD_ALLOC;
            r_g     <= '0;
            r_pend  <= 1'b0;
            r_bump  <= '0;
            r_blk   <= '0;
            r_gran  <= '0;
            r_pool  <= 13'd4096;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_g     <= n_g;
            r_pend  <= n_pend;
            r_bump  <= n_bump;
            r_blk   <= n_blk;
            r_gran  <= n_gran;
            r_done  <= n_done;
            if (i_cfg_valid) r_pool <= i_cfg_data;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_st <= n_st; r_pg <= n_pg; r_req <= n_req; r_a <= n_a; r_ao <= n_ao;
        r_n <= n_n; r_fs <= n_fs; r_bg <= n_bg; r_bs <= n_bs; r_bc <= n_bc;
        r_hit <= n_hit; r_lm <= n_lm; r_rm <= n_rm; r_grant <= n_grant;
        r_ostat <= n_ostat; r_oaddr <= n_oaddr; r_ocnt <= n_ocnt;
        r_obytes <= n_obytes;
    end

    assign o_done             = r_done;
    assign o_status           = r_ostat;
    assign o_granted_addr     = r_oaddr;
    assign o_free_block_count = r_ocnt;
    assign o_free_byte_total  = r_obytes;

endmodule

[hw/rtl/sfha_checker.sv]
// ----------------------------------------------------------------------------
// sfha_checker
// Port-level checks on the allocator's command and result timing.
// ----------------------------------------------------------------------------
`include "segregated_fit_heap_allocator_top_assert.svh"

module sfha_checker
    import sfha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [17:0] o_granted_addr
);

    // an accepted request keeps the block busy
    `SFHA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "not busy after request")

    // one result strobe per request, never back to back
    `SFHA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe repeated")

    // no address unless the request succeeded
    `SFHA_ASSERT_NOW(a_addr_zero, i_clk, i_rst_n, o_done && (o_status != ST_OK),
        o_granted_addr == '0, "address on failed request")

endmodule

bind segregated_fit_heap_allocator_top sfha_checker u_sfha_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_status(o_status), .o_granted_addr(o_granted_addr)
);
